// ----- hw/rtl/dhlt_pkg.sv -----
// Shared constants, types and functions for the DH link transform.
package dhlt_pkg;

  localparam int CordicStages = 20;
  localparam int ZW = 28;   // residual angle width, units of 2^-24
  localparam int XW = 26;   // CORDIC x/y width

  localparam logic signed [XW-1:0] GainInv = 26'sd10188014;
  localparam logic signed [ZW-1:0] PiQ24 = 28'sd52707179;
  localparam logic signed [ZW-1:0] HalfPiQ24 = 28'sd26353589;

  localparam logic [1:0] RegOffset = 2'd0;
  localparam logic [1:0] RegLength = 2'd1;
  localparam logic [1:0] RegTwist = 2'd2;

  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 28'sd13176795;
      1: r = 28'sd7778716;
      2: r = 28'sd4110060;
      3: r = 28'sd2086331;
      4: r = 28'sd1047214;
      5: r = 28'sd524117;
      6: r = 28'sd262123;
      7: r = 28'sd131069;
      default: r = ZW'(32'sd65536 >>> (i - 8));
    endcase
    return r;
  endfunction

  // CORDIC state for one angle
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic flip;
  } cordic_t;

  typedef struct packed {
    logic signed [15:0] c;
    logic signed [15:0] s;
  } trig_t;

  // round v/2^10 to nearest, clamp to +-1.0
  function automatic logic signed [15:0] round_q14(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = (v + XW'(512)) >>> 10;
    if (r > XW'(16384)) return 16'sd16384;
    if (r < -XW'(16384)) return -16'sd16384;
    return r[15:0];
  endfunction

endpackage

// ----- hw/rtl/dhlt_cordic.sv -----
// Pipelined rotation-mode CORDIC for theta and alpha, one stage per register.
module dhlt_cordic (
  input  logic clk,
  input  logic en,
  input  logic signed [15:0] theta,
  input  logic signed [15:0] alpha,
  output dhlt_pkg::trig_t trig_t_out,
  output dhlt_pkg::trig_t trig_a_out
);
  localparam int N = dhlt_pkg::CordicStages;

  dhlt_pkg::cordic_t st_t [N+1];
  dhlt_pkg::cordic_t st_a [N+1];

  function automatic dhlt_pkg::cordic_t fold(input logic signed [15:0] ang);
    dhlt_pkg::cordic_t r;
    logic signed [dhlt_pkg::ZW-1:0] z;
    z = dhlt_pkg::ZW'(ang) <<< 11;
    r.x = dhlt_pkg::GainInv;
    r.y = '0;
    r.flip = 1'b0;
    r.z = z;
    if (z > dhlt_pkg::HalfPiQ24) begin
      r.z = z - dhlt_pkg::PiQ24;
      r.flip = 1'b1;
    end else if (z < -dhlt_pkg::HalfPiQ24) begin
      r.z = z + dhlt_pkg::PiQ24;
      r.flip = 1'b1;
    end
    return r;
  endfunction

  function automatic dhlt_pkg::cordic_t rot(input dhlt_pkg::cordic_t a, input int i);
    dhlt_pkg::cordic_t r;
    r = a;
    if (!a.z[dhlt_pkg::ZW-1]) begin
      r.x = a.x - (a.y >>> i);
      r.y = a.y + (a.x >>> i);
      r.z = a.z - dhlt_pkg::atan_q24(i);
    end else begin
      r.x = a.x + (a.y >>> i);
      r.y = a.y - (a.x >>> i);
      r.z = a.z + dhlt_pkg::atan_q24(i);
    end
    return r;
  endfunction

  function automatic dhlt_pkg::trig_t fin(input dhlt_pkg::cordic_t a);
    dhlt_pkg::trig_t r;
    logic signed [dhlt_pkg::XW-1:0] x;
    logic signed [dhlt_pkg::XW-1:0] y;
    x = a.flip ? -a.x : a.x;
    y = a.flip ? -a.y : a.y;
    r.c = dhlt_pkg::round_q14(x);
    r.s = dhlt_pkg::round_q14(y);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      st_t[0] <= fold(theta);
      st_a[0] <= fold(alpha);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        st_t[i+1] <= rot(st_t[i], i);
        st_a[i+1] <= rot(st_a[i], i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig_t_out <= fin(st_t[N]);
      trig_a_out <= fin(st_a[N]);
    end
  end
endmodule

// ----- hw/rtl/dhlt_products.sv -----
// Products of the trig values: multiply stage, then round/saturate stage.
module dhlt_products (
  input  logic clk,
  input  logic en,
  input  dhlt_pkg::trig_t tt,
  input  dhlt_pkg::trig_t ta,
  input  logic signed [15:0] len,
  input  logic signed [15:0] ofs,
  output logic [175:0] res
);
  logic signed [31:0] p_scs, p_ssa, p_cca, p_csa, p_lc, p_ls;
  dhlt_pkg::trig_t tt1, ta1;
  logic signed [15:0] ofs1;

  function automatic logic signed [15:0] rnd(input logic signed [31:0] p,
                                             input logic unit);
    logic signed [32:0] r;
    r = (33'(p) + 33'sd8192) >>> 14;
    if (unit) begin
      if (r > 33'sd16384) return 16'sd16384;
      if (r < -33'sd16384) return -16'sd16384;
    end else begin
      if (r > 33'sd32767) return 16'sd32767;
      if (r < -33'sd32768) return -16'sd32768;
    end
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p_scs <= tt.s * ta.c;
      p_ssa <= tt.s * ta.s;
      p_cca <= tt.c * ta.c;
      p_csa <= tt.c * ta.s;
      p_lc <= len * tt.c;
      p_ls <= len * tt.s;
      tt1 <= tt;
      ta1 <= ta;
      ofs1 <= ofs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= {ofs1, rnd(p_ls, 1'b0), rnd(p_lc, 1'b0), ta1.c, ta1.s,
              -rnd(p_csa, 1'b1), rnd(p_cca, 1'b1), tt1.s, rnd(p_ssa, 1'b1),
              -rnd(p_scs, 1'b1), tt1.c};
    end
  end
endmodule

// ----- hw/rtl/dh_link_transform_top.sv -----
// Top level of the DH link transform: config port, stream handshake, pipeline.
//
// channel  | dir | word
// s_axis   | in  | tdata[15:0] joint_angle
// m_axis   | out | tdata[175:0] rot_11..rot_33, pos_x, pos_y, pos_z
// apb      | in  | regs link_offset @0, link_length @4, link_twist @8
//
// One word per cycle unless m_axis stalls; stages in order: fold, 20 CORDIC stages,
// round, multiply, round/saturate. The CORDIC stage count sets the pipeline depth.
// Reset (rst, sync) clears valid bits and config registers. A stall on m_axis
// freezes the whole pipeline in place; nothing is lost or repeated.
module dh_link_transform_top (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // joint_angle
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [175:0] m_axis_tdata,  // rot_11,12,13,21,22,23,32,33,pos_x,y,z
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int Lat = dhlt_pkg::CordicStages + 4;

  logic signed [15:0] link_offset, link_length, link_twist;
  logic [Lat-1:0] vld;
  logic en;
  dhlt_pkg::trig_t tt, ta;

  assign pready = 1'b1;
  // pipeline advances unless the output word is held
  assign en = !vld[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      link_offset <= '0;
      link_length <= '0;
      link_twist <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        dhlt_pkg::RegOffset: link_offset <= pwdata[15:0];
        dhlt_pkg::RegLength: link_length <= pwdata[15:0];
        dhlt_pkg::RegTwist: link_twist <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dhlt_pkg::RegOffset: prdata = {{16{link_offset[15]}}, link_offset};
      dhlt_pkg::RegLength: prdata = {{16{link_length[15]}}, link_length};
      dhlt_pkg::RegTwist: prdata = {{16{link_twist[15]}}, link_twist};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], s_axis_tvalid};
  end

  dhlt_cordic u_cordic (
    .clk(clk), .en(en), .theta(s_axis_tdata), .alpha(link_twist),
    .trig_t_out(tt), .trig_a_out(ta)
  );

  dhlt_products u_prod (
    .clk(clk), .en(en), .tt(tt), .ta(ta), .len(link_length),
    .ofs(link_offset), .res(m_axis_tdata)
  );

  // held output word stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");
  // input taken whenever output is free
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
  // rot_11 stays within +-1.0
  a_unit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
    $signed(m_axis_tdata[15:0]) >= -16'sd16384)
    else $error("rot_11 out of range");
endmodule

// ----- tb/sv/dhlt_checker.sv -----
// Checker for the DH link transform: predicts each output word and compares.
`timescale 1ns / 100ps
module dhlt_checker (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic [175:0] m_axis_tdata,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  input  logic pready,
  output int fail_count,
  output int pending
);
  localparam int NumFields = 11;
  localparam logic signed [63:0] KGain = 64'sd10188014;
  localparam logic signed [63:0] PiFix = 64'sd52707179;
  localparam logic signed [63:0] HalfPiFix = 64'sd26353589;

  logic signed [15:0] offset_q, length_q, twist_q;
  logic [175:0] transform_q[$];

  function automatic logic signed [63:0] arctan_step(input int i);
    case (i)
      0: return 64'sd13176795;
      1: return 64'sd7778716;
      2: return 64'sd4110060;
      3: return 64'sd2086331;
      4: return 64'sd1047214;
      5: return 64'sd524117;
      6: return 64'sd262123;
      7: return 64'sd131069;
      default: return 64'sd65536 >>> (i - 8);
    endcase
  endfunction

  function automatic logic signed [63:0] clip(input logic signed [63:0] v,
                                              input logic signed [63:0] lo,
                                              input logic signed [63:0] hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // cos/sin of a Q3.13 angle, Q1.14 results
  function automatic void cos_sin(input logic signed [15:0] ang,
                                  output logic signed [15:0] c,
                                  output logic signed [15:0] s);
    logic signed [63:0] x, y, z, nx, ny;
    bit flip;
    x = KGain; y = 0; z = 64'(ang) * 2048; flip = 0;
    if (z > HalfPiFix) begin
      z -= PiFix; flip = 1;
    end else if (z < -HalfPiFix) begin
      z += PiFix; flip = 1;
    end
    for (int i = 0; i < dhlt_pkg::CordicStages; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= arctan_step(i);
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += arctan_step(i);
      end
      x = nx; y = ny;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = 16'(clip((x + 512) >>> 10, -16384, 16384));
    s = 16'(clip((y + 512) >>> 10, -16384, 16384));
  endfunction

  function automatic logic signed [15:0] scale(input logic signed [15:0] p,
                                               input logic signed [15:0] q,
                                               input bit is_len);
    logic signed [63:0] r;
    r = (64'(p) * 64'(q) + 8192) >>> 14;
    return is_len ? 16'(clip(r, -32768, 32767)) : 16'(clip(r, -16384, 16384));
  endfunction

  function automatic logic [175:0] link_transform(input logic signed [15:0] theta);
    logic signed [15:0] ct, st, ca, sa;
    logic [175:0] w;
    cos_sin(theta, ct, st);
    cos_sin(twist_q, ca, sa);
    w[15:0] = ct;
    w[31:16] = -scale(st, ca, 0);
    w[47:32] = scale(st, sa, 0);
    w[63:48] = st;
    w[79:64] = scale(ct, ca, 0);
    w[95:80] = -scale(ct, sa, 0);
    w[111:96] = sa;
    w[127:112] = ca;
    w[143:128] = scale(length_q, ct, 1);
    w[159:144] = scale(length_q, st, 1);
    w[175:160] = offset_q;
    return w;
  endfunction

  assign pending = transform_q.size();

  always @(posedge clk) begin
    logic [175:0] want;
    if (rst) begin
      offset_q <= '0; length_q <= '0; twist_q <= '0;
      fail_count <= 0;
      transform_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          dhlt_pkg::RegOffset: offset_q <= pwdata[15:0];
          dhlt_pkg::RegLength: length_q <= pwdata[15:0];
          dhlt_pkg::RegTwist: twist_q <= pwdata[15:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (transform_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = transform_q.pop_front();
          for (int f = 0; f < NumFields; f++) begin
            if (m_axis_tdata[16*f +: 16] !== want[16*f +: 16]) begin
              if (fail_count < 10)
                $display("field %0d: expected %h got %h", f, want[16*f +: 16],
                         m_axis_tdata[16*f +: 16]);
              fail_count <= fail_count + 1;
              break;
            end
          end
        end
      end
      // config never changes while words are in flight, so current regs apply
      if (s_axis_tvalid && s_axis_tready)
        transform_q.push_back(link_transform(s_axis_tdata));
    end
  end
endmodule

// ----- tb/sv/tb.sv -----
// Testbench top: drives joint angles and register writes, reports the verdict.
`timescale 1ns / 100ps
module tb;
  localparam int Latency = 24;
  localparam int RandomWords = 1000;

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [175:0] m_axis_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  int fail_count, pending;

  // stall control for the receiver side
  bit sink_idle = 1;      // random back-pressure enabled
  bit sink_hold = 0;      // long hold-off requested

  always #10 clk = ~clk;

  dh_link_transform_top u_dut (.*);

  dhlt_checker u_chk (.*);

  // Receiver: random stall bursts, or a long counted hold-off on request.
  initial begin
    @(negedge clk);
    forever begin
      if (sink_hold) begin
        m_axis_tready <= 0;
        repeat (80) @(negedge clk);
        sink_hold = 0;
      end else if (sink_idle && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        m_axis_tready <= 1;
        @(negedge clk);
      end
    end
  end

  // One register write: setup then access cycle.
  task automatic reg_write(input logic [1:0] idx, input logic signed [15:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00};
    pwdata <= {{16{v[15]}}, v};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_link(input logic signed [15:0] d, input logic signed [15:0] a,
                          input logic signed [15:0] alpha);
    reg_write(dhlt_pkg::RegOffset, d);
    reg_write(dhlt_pkg::RegLength, a);
    reg_write(dhlt_pkg::RegTwist, alpha);
  endtask

  // Offer one angle and hold it until accepted; optional idle gap first.
  task automatic send_angle(input logic [15:0] theta, input bit gaps);
    bit taken;
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= theta;
    // tready is settled shortly after the falling edge and holds to the rising one
    do begin
      #1 taken = s_axis_tready;
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 51472)) - 16'd25736;   // within +-pi
      1: return 16'($urandom);                               // full range, beyond pi
      2: return 16'($urandom_range(0, 600)) + 16'd12568;     // near +pi/2 fold
      default: return 16'(-$signed(16'($urandom_range(12268, 12868))));
    endcase
  endfunction

  initial begin
    logic [15:0] corners[$] = '{16'h0000, 16'h7FFF, 16'h8000, 16'd25736, -16'sd25736,
                                16'd12868, -16'sd12868, 16'd6434, 16'hFFFF, 16'h0001,
                                16'd25737, 16'd12867, 16'hAAAA, 16'h5555};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: reset config, then saturating length and twist extremes
    foreach (corners[i]) send_angle(corners[i], 0);
    drain();
    set_link(16'sh7FFF, -16'sd32768, 16'sd25736);
    foreach (corners[i]) send_angle(corners[i], 0);
    drain();
    set_link(-16'sd32768, 16'sh7FFF, -16'sd25736);
    for (int i = 0; i < 6; i++) send_angle(corners[i], 0);
    drain();

    // random phases with fresh link settings; the last one has no idling
    for (int ph = 0; ph < 8; ph++) begin
      set_link(16'($urandom), 16'($urandom),
               ph == 3 ? 16'h8000 : (ph == 4 ? 16'h7FFF : 16'($urandom)));
      if (ph == 7) sink_idle = 0;
      for (int n = 0; n < RandomWords / 8; n++) begin
        if (ph == 2 && n == 10) sink_hold = 1;   // input backs up behind this
        if (ph == 5 && n == 60) begin
          s_axis_tvalid <= 0;                    // pause until all words are out
          while (pending != 0) @(negedge clk);
        end
        send_angle(rand_angle(), ph != 7);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
